[rtl/spq_pkg.sv]
// Package for the sorted priority queue: field widths, status codes and
// sequencer states. No dependencies.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int PRI_W         = 16;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [PRI_W-1:0]          pri_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_REM_RD,
    S_REM_CMP,
    S_HEAD_RD,
    S_HEAD_CAP
  } state_t;

endpackage

[rtl/spq_in_if.sv]
// Request channel of the sorted priority queue: valid/ready and the
// request fields. Depends on spq_pkg.
interface spq_in_if;
  import spq_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  value_t item_value;
  pri_t   item_priority;

  modport source (output valid, output action, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input action, input item_value,
                  input item_priority, output ready);
endinterface

[rtl/spq_out_if.sv]
// Result channel of the sorted priority queue: valid/ready and the
// result fields. Depends on spq_pkg.
interface spq_out_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  head_value;
  pri_t    head_priority;
  count_t  entry_count;
  logic    is_empty;

  modport source (output valid, output status, output head_value,
                  output head_priority, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input head_value,
                  input head_priority, input entry_count, input is_empty,
                  output ready);
endinterface

[rtl/sorted_priority_queue.sv]
// An insert shifts up every entry of priority >= the new one; a remove scans all
// stored entries; an insert into a full queue goes straight to the result.
// One request at a time; each step is a read-compare-write on the single
// entry memory, which sets the rate. A result waits in the output register.
// Reset (rst_n, synchronous, active low) empties the queue; the entry
// memory is not cleared, only entries below the count are read.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  value_t mem_val [DEPTH];
  pri_t   mem_pri [DEPTH];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  status_t           status_r, status_nxt;
  value_t            val_r, val_nxt;
  pri_t              pri_r, pri_nxt;
  value_t            rd_val_r;
  pri_t              rd_pri_r;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  value_t            out_value_r;
  pri_t              out_pri_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_empty_r;
  logic              out_load;

  logic              we;
  logic [IDX_W-1:0]  wa;
  value_t            wd_val;
  pri_t              wd_pri;
  logic [IDX_W-1:0]  ra;
  logic              in_acc;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign in_acc = in_ch.valid && in_ch.ready;

  // next state and sequencer registers
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    val_nxt    = val_r;
    pri_nxt    = pri_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt    = in_ch.item_value;
          pri_nxt    = in_ch.item_priority;
          status_nxt = ST_DONE;
          found_nxt  = 1'b0;
          if (in_ch.action == ACT_REMOVE) begin
            k_nxt     = '0;
            state_nxt = S_REM_RD;
          end else if (cnt_r == DEPTH_C) begin
            status_nxt = ST_FULL;
            state_nxt  = S_HEAD_RD;
          end else begin
            k_nxt     = cnt_r;
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (k_r == '0) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_HEAD_RD;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (rd_pri_r >= pri_r) begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_HEAD_RD;
        end
      end
      S_REM_RD: begin
        if (k_r == cnt_r) begin
          if (found_r) cnt_nxt = cnt_r - 1'b1;
          else status_nxt = ST_NOTFOUND;
          state_nxt = S_HEAD_RD;
        end else begin
          state_nxt = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (!found_r && rd_val_r == val_r) found_nxt = 1'b1;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_REM_RD;
      end
      S_HEAD_RD: state_nxt = S_HEAD_CAP;
      S_HEAD_CAP: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory controls, handshake and output load
  always_comb begin
    we     = 1'b0;
    wa     = k_r[IDX_W-1:0];
    wd_val = val_r;
    wd_pri = pri_r;
    ra     = '0;
    out_load = 1'b0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      S_IDLE: in_ch.ready = 1'b1;
      S_INS_RD: begin
        ra = IDX_W'(k_r - 1'b1);
        we = (k_r == '0);
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rd_pri_r >= pri_r) begin
          wd_val = rd_val_r;
          wd_pri = rd_pri_r;
        end
      end
      S_REM_RD: ra = k_r[IDX_W-1:0];
      S_REM_CMP: begin
        we     = found_r;
        wa     = IDX_W'(k_r - 1'b1);
        wd_val = rd_val_r;
        wd_pri = rd_pri_r;
      end
      S_HEAD_RD: ra = '0;
      S_HEAD_CAP: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_val[wa] <= wd_val;
      mem_pri[wa] <= wd_pri;
    end
    rd_val_r <= mem_val[ra];
    rd_pri_r <= mem_pri[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
    pri_r    <= pri_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_cnt_r    <= cnt_r;
      out_empty_r  <= (cnt_r == '0);
      out_value_r  <= (cnt_r == '0) ? '0 : rd_val_r;
      out_pri_r    <= (cnt_r == '0) ? '0 : rd_pri_r;
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, out_cnt_r};

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.head_value    = out_value_r;
  assign out_ch.head_priority = out_pri_r;
  assign out_ch.entry_count   = cnt_ext[COUNT_W-1:0];
  assign out_ch.is_empty      = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("entry count above depth");

  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> ({1'b0, wa} <= cnt_r)) else $error("write beyond stored entries");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(state_r) == S_INS_RD ||
      $past(state_r) == S_INS_CMP || $past(state_r) == S_REM_RD))
    else $error("count changed outside an update step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not return to idle");

endmodule

[verif/spq_checker.sv]
// Checker for the sorted priority queue: watches the request and result channels,
// predicts each result from its own copy of the queue and compares field by field.
// Depends on spq_pkg, spq_in_if and spq_out_if.
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    in_ch,
  spq_out_if   out_ch,
  output int   mismatch_count,
  output int   outstanding
);
  import spq_pkg::*;

  typedef struct packed {
    status_t status;
    value_t  head_value;
    pri_t    head_priority;
    count_t  entry_count;
    logic    is_empty;
  } queue_result_t;

  value_t        slot_val [DEPTH];
  pri_t          slot_pri [DEPTH];
  int            occupancy;
  queue_result_t expected_q [$];

  function automatic queue_result_t apply_request(action_t act, value_t v, pri_t p);
    queue_result_t r;
    int pos;
    r.status = ST_DONE;
    pos = 0;
    if (act == ACT_INSERT) begin
      if (occupancy >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        while (pos < occupancy && slot_pri[pos] < p) pos++;
        for (int k = occupancy; k > pos; k--) begin
          slot_val[k] = slot_val[k-1];
          slot_pri[k] = slot_pri[k-1];
        end
        slot_val[pos] = v;
        slot_pri[pos] = p;
        occupancy++;
      end
    end else begin
      while (pos < occupancy && slot_val[pos] != v) pos++;
      if (pos >= occupancy) begin
        r.status = ST_NOTFOUND;
      end else begin
        for (int k = pos; k + 1 < occupancy; k++) begin
          slot_val[k] = slot_val[k+1];
          slot_pri[k] = slot_pri[k+1];
        end
        occupancy--;
      end
    end
    r.head_value    = (occupancy > 0) ? slot_val[0] : '0;
    r.head_priority = (occupancy > 0) ? slot_pri[0] : '0;
    r.entry_count   = count_t'(occupancy);
    r.is_empty      = (occupancy == 0);
    return r;
  endfunction

  task automatic report_field(string field, longint want_v, longint got_v);
    $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      occupancy = 0;
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status        = out_ch.status;
        got.head_value    = out_ch.head_value;
        got.head_priority = out_ch.head_priority;
        got.entry_count   = out_ch.entry_count;
        got.is_empty      = out_ch.is_empty;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none got status %0d",
                   $time, got.status);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status)
            report_field("status", want.status, got.status);
          if (got.head_value !== want.head_value)
            report_field("head_value", want.head_value, got.head_value);
          if (got.head_priority !== want.head_priority)
            report_field("head_priority", want.head_priority, got.head_priority);
          if (got.entry_count !== want.entry_count)
            report_field("entry_count", want.entry_count, got.entry_count);
          if (got.is_empty !== want.is_empty)
            report_field("is_empty", want.is_empty, got.is_empty);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(apply_request(action_t'(in_ch.action), in_ch.item_value,
                                           in_ch.item_priority));
    end
    outstanding <= expected_q.size();
  end

endmodule

[verif/tb.sv]
// Testbench top for the sorted priority queue: clock, reset, request stimulus with
// random gaps, result back-pressure and the verdict. Depends on spq_pkg, the two
// channel interfaces, sorted_priority_queue and spq_checker.
module tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH     = DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1030;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 60;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int   stall_left = 0;
  int   mismatch_count;
  int   outstanding;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_checker #(.DEPTH(QUEUE_DEPTH)) queue_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return value_t'($urandom);
    if (r < 80) return value_t'($urandom_range(0, 7)) - 4;
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -1;
      default: return 0;
    endcase
  endfunction

  // hold the request until accepted, then idle for a random gap
  task automatic push_request(action_t act, value_t v, pri_t p);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.item_value    <= v;
    in_ch.item_priority <= p;
    do @(posedge clk); while (!in_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  initial begin
    value_t v;
    pri_t   pri;
    int     r;
    int     idx;
    int     insert_pct;
    value_t recent [$];
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_INSERT;
    in_ch.item_value    <= '0;
    in_ch.item_priority <= '0;
    insert_pct = 50;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // remove on empty, extremes, equal priorities, fill past full, duplicates, miss
    push_request(ACT_REMOVE, 32'sd5, '0);
    push_request(ACT_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    push_request(ACT_INSERT, 32'sh8000_0000, 16'h0000);
    push_request(ACT_INSERT, 32'sd0, 16'h0000);
    push_request(ACT_INSERT, 32'sd1, 16'hFFFF);
    push_request(ACT_REMOVE, 32'sh8000_0000, 16'hFFFF);
    push_request(ACT_REMOVE, 32'sh7FFF_FFFF, 16'h0000);
    for (int k = 0; k < 15; k++)
      push_request(ACT_INSERT, (k % 3 == 0) ? 32'sh5555_5555 : value_t'(-k),
                   pri_t'(k * 4681));
    push_request(ACT_REMOVE, 32'sh5555_5555, '0);
    push_request(ACT_REMOVE, 32'sh1234_5678, '0);
    wait_results_done();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
        calm <= ($urandom_range(0, 4) == 0);
      end
      if (n == RANDOM_REQUESTS / 2) wait_results_done();
      if ($urandom_range(0, 99) < insert_pct) begin
        r = $urandom_range(0, 99);
        if (r < 40)      pri = pri_t'($urandom_range(0, 65535));
        else if (r < 80) pri = pri_t'($urandom_range(0, 3));
        else             pri = r[0] ? '1 : '0;
        v = pick_value();
        push_request(ACT_INSERT, v, pri);
        recent.push_back(v);
        if (recent.size() > 32) void'(recent.pop_front());
      end else begin
        if (recent.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, recent.size() - 1);
          v   = recent[idx];
          recent.delete(idx);
        end else begin
          v = pick_value();
        end
        push_request(ACT_REMOVE, v, pri_t'($urandom_range(0, 65535)));
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
